>>> rtl/core/vrct_pkg.sv
package vrct_pkg;

    // fixed field widths of one input word
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 30;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // kind codes
    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    // payload travelling down the chain (valid bit kept apart, it is reset)
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic [CNT_W-1:0] cnt;
    } item_t;

endpackage

>>> rtl/core/vrct_cell.sv
module vrct_cell #(
    parameter int VALUE_BITS = 30,
    parameter int CELL_INDEX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           in_vld,
    input  vrct_pkg::item_t in_item,
    output logic           out_vld,
    output vrct_pkg::item_t out_item
);

    localparam int CMP_W = (VALUE_BITS > vrct_pkg::VAL_W) ? VALUE_BITS : vrct_pkg::VAL_W;
    localparam bit IDX_REACHABLE = (CELL_INDEX < (1 << vrct_pkg::IDX_W));

    logic [VALUE_BITS-1:0] value_reg;
    logic                  entry_valid_reg;
    logic                  vld_reg;
    vrct_pkg::item_t       item_reg;
    vrct_pkg::item_t       item_next;

    logic hit_set;
    logic in_range;

    assign hit_set = in_vld && (in_item.kind == vrct_pkg::KIND_SET) && IDX_REACHABLE
                     && (in_item.idx == vrct_pkg::IDX_W'(CELL_INDEX));

    assign in_range = entry_valid_reg
                      && (CMP_W'(value_reg) >= CMP_W'(in_item.lo))
                      && (CMP_W'(value_reg) <= CMP_W'(in_item.hi));

    always_comb begin
        item_next = in_item;
        if (in_vld && (in_item.kind == vrct_pkg::KIND_COUNT) && in_range
            && (in_item.cnt != vrct_pkg::COUNT_MAX)) begin
            item_next.cnt = in_item.cnt + vrct_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            vld_reg         <= 1'b0;
        end else if (advance) begin
            vld_reg <= in_vld;
            if (hit_set) begin
                entry_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
            if (hit_set) begin
                value_reg <= VALUE_BITS'(in_item.val);
            end
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

    // a set hit lands in this cell
    a_set_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit_set) |=> (entry_valid_reg
                                  && value_reg == VALUE_BITS'($past(in_item.val))))
        else $error("set word did not land in its cell");

    // an entry once valid never drops
    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_valid_reg |=> entry_valid_reg)
        else $error("entry valid flag dropped");

    // a stall freezes the slot
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> (vld_reg == $past(vld_reg)))
        else $error("chain slot moved during stall");

    // count passing a cell only grows
    a_cnt_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_vld && in_item.kind == vrct_pkg::KIND_COUNT)
        |=> (item_reg.cnt >= $past(in_item.cnt)))
        else $error("running count shrank");

endmodule

>>> rtl/core/vrct_out_stage.sv
module vrct_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       tail_vld,
    input  vrct_pkg::item_t            tail_item,
    output logic                       advance,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [vrct_pkg::CNT_W-1:0] m_count
);

    logic                       out_vld_reg;
    logic                       out_vld_next;
    logic [vrct_pkg::CNT_W-1:0] count_reg;

    // chain moves whenever the result slot is free or being drained
    assign advance = !out_vld_reg || m_tready;

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = tail_vld && (tail_item.kind == vrct_pkg::KIND_COUNT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && tail_vld) begin
            count_reg <= tail_item.cnt;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_count  = count_reg;

endmodule

>>> rtl/core/value_range_count_table_core.sv
// Path: an accepted word passes through every chain cell in order, then the result register,
//   to reach m_tvalid; it is held back while a low m_tready stalls the chain.
// Throughput: one word per cycle, set or count, barring m_tready stalls; fully pipelined chain.
// Reset: synchronous, active-low aresetn clears every cell's entry-valid flag and all
//   slot-valid flags; no clearing pass. Stored values are left as they are.
module value_range_count_table_core #(
    parameter int NUM_ENTRIES = 1024,
    parameter int VALUE_BITS  = 30
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // [9:0] entry_index, [39:10] new_value, [69:40] range_low, [99:70] range_high,
    // [103:100] zero
    input  logic [103:0] s_tdata,
    // [0] kind (0 = set, 1 = count)
    input  logic [0:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // [10:0] match_count, [15:11] zero
    output logic [15:0]  m_tdata
);

    // Each cell owns one table entry. Words walk down the chain in order, so a
    // count word sees exactly the set words that were accepted ahead of it:
    // a set ahead of it reaches each cell first, one behind it arrives later.
    // Count words pick up one at each valid cell whose value is in range;
    // the running count saturates at its 11-bit maximum.

    logic                       advance;
    logic                       chain_vld  [NUM_ENTRIES+1];
    vrct_pkg::item_t            chain_item [NUM_ENTRIES+1];
    logic [vrct_pkg::CNT_W-1:0] m_count;

    // a word is taken whenever the chain moves
    assign s_tready = advance;

    assign chain_vld[0]       = s_tvalid;
    assign chain_item[0].kind = s_tuser[0];
    assign chain_item[0].idx  = s_tdata[9:0];
    assign chain_item[0].val  = s_tdata[39:10];
    assign chain_item[0].lo   = s_tdata[69:40];
    assign chain_item[0].hi   = s_tdata[99:70];
    assign chain_item[0].cnt  = '0;

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        vrct_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CELL_INDEX (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_vld   (chain_vld[g]),
            .in_item  (chain_item[g]),
            .out_vld  (chain_vld[g+1]),
            .out_item (chain_item[g+1])
        );
    end

    // result register; set words leave the chain here and are dropped
    vrct_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tail_vld  (chain_vld[NUM_ENTRIES]),
        .tail_item (chain_item[NUM_ENTRIES]),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_count   (m_count)
    );

    assign m_tdata = {5'b0, m_count};

    // a count word at the chain tail becomes a result when the chain moves
    a_tail_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && chain_vld[NUM_ENTRIES]
         && chain_item[NUM_ENTRIES].kind == vrct_pkg::KIND_COUNT) |=> m_tvalid)
        else $error("count word lost at chain tail");

    // a set word at the tail never makes a result
    a_set_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !(chain_vld[NUM_ENTRIES]
                      && chain_item[NUM_ENTRIES].kind == vrct_pkg::KIND_COUNT))
        |=> !m_tvalid)
        else $error("result raised without a count word");

    // count cannot exceed the number of cells
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_count) <= NUM_ENTRIES))
        else $error("count exceeds table size");

endmodule
